### design/frame_delimiter_checksum_check_top_defines.svh
// assertion macros used by the frame check design
`ifndef FRAME_DELIMITER_CHECKSUM_CHECK_TOP_DEFINES_SVH
`define FRAME_DELIMITER_CHECKSUM_CHECK_TOP_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define FDC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequence in the same cycle
`define FDC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the following cycle
`define FDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/fdc_pkg.sv
// types and constants of the frame delimiter and checksum check
`default_nettype none

package fdc_pkg;

    localparam int MAX_FRAME_DEF = 256;
    localparam int LEN_W         = 9;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_W         = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;

    typedef enum logic [0:0] {
        CMD_BYTE = 1'b0,
        CMD_IDLE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DELIM = 2'd1,
        ST_LEN   = 2'd2,
        ST_SUM   = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [LEN_W-1:0]   frame_length;
    } t_result;

endpackage

`default_nettype wire

### design/fdc_in_reg.sv
// input register holding one received transaction
`default_nettype none

module fdc_in_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire fdc_pkg::t_item i_item,
    input  wire                 i_take,
    output logic                o_valid,
    output fdc_pkg::t_item      o_item
);
    import fdc_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_take) begin
            n_valid = 1'b0;
        end
        if (o_ready && i_valid) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

### design/fdc_frame.sv
// frame state, marker registers and the closing judgement
`default_nettype none
`include "frame_delimiter_checksum_check_top_defines.svh"

module fdc_frame #(
    parameter int MAX_FRAME = fdc_pkg::MAX_FRAME_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [fdc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [fdc_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire                                 i_valid,
    input  wire  fdc_pkg::t_item                i_item,
    input  wire                                 i_out_free,
    output logic                                o_take,
    output logic                                o_load,
    output fdc_pkg::t_result                    o_res
);
    import fdc_pkg::*;

    localparam int CntW  = $clog2(MAX_FRAME + 1);
    localparam int WideW = CntW + 8;

    logic [7:0]      r_start;
    logic [7:0]      r_end;
    logic [CntW-1:0] r_count, n_count;
    logic [7:0]      r_first, n_first;
    logic [7:0]      r_decl, n_decl;
    logic [7:0]      r_last, n_last;
    logic [7:0]      r_before, n_before;
    logic [7:0]      r_sum, n_sum;

    logic [CntW+LEN_W-1:0] w_cnt_len;
    logic [WideW-1:0]      w_cnt_wide;
    logic [WideW-1:0]      w_decl_wide;
    logic                  w_idle;

    assign w_idle = (i_item.command == CMD_IDLE);
    assign o_take = i_valid && (!w_idle || i_out_free);
    assign o_load = o_take && w_idle;

    // reported length is the count masked to the field width
    assign w_cnt_len   = (CntW + LEN_W)'(r_count);
    assign w_cnt_wide  = WideW'(r_count);
    assign w_decl_wide = WideW'(r_decl);

    always_comb begin
        o_res.frame_length = w_cnt_len[LEN_W-1:0];
        if (r_count < CntW'(2) || r_first != r_start || r_last != r_end) begin
            o_res.status = ST_DELIM;
        end else if (w_cnt_wide < w_decl_wide) begin
            o_res.status = ST_LEN;
        end else if (r_sum != r_before) begin
            o_res.status = ST_SUM;
        end else begin
            o_res.status = ST_OK;
        end
    end

    always_comb begin
        n_count  = r_count;
        n_first  = r_first;
        n_decl   = r_decl;
        n_last   = r_last;
        n_before = r_before;
        n_sum    = r_sum;
        if (o_take) begin
            if (w_idle) begin
                n_count  = '0;
                n_first  = '0;
                n_decl   = '0;
                n_last   = '0;
                n_before = '0;
                n_sum    = '0;
            end else if (r_count < CntW'(MAX_FRAME)) begin
                if (r_count == '0) begin
                    n_first = i_item.data_byte;
                end
                if (r_count == CntW'(1)) begin
                    n_decl = i_item.data_byte;
                end
                // the trailing two bytes stay out of the sum until pushed out
                if (r_count >= CntW'(2)) begin
                    n_sum = r_sum + r_before;
                end
                n_before = r_last;
                n_last   = i_item.data_byte;
                n_count  = r_count + CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_first  <= '0;
            r_decl   <= '0;
            r_last   <= '0;
            r_before <= '0;
            r_sum    <= '0;
        end else begin
            r_count  <= n_count;
            r_first  <= n_first;
            r_decl   <= n_decl;
            r_last   <= n_last;
            r_before <= n_before;
            r_sum    <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START: r_start <= i_cfg_data;
                CFG_END:   r_end   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    `FDC_ASSERT_ALWAYS(a_count_cap, r_count <= CntW'(MAX_FRAME), "byte count past capacity")
    `FDC_ASSERT_NEXT(a_idle_clears, o_load, r_count == '0 && r_sum == '0, "frame not cleared")
    `FDC_ASSERT_SAME(a_ok_framed, o_load && o_res.status == ST_OK,
        r_count >= CntW'(2) && r_first == r_start && r_last == r_end, "ok status on bad frame")
    `FDC_ASSERT_SAME(a_load_room, o_load, i_out_free, "result loaded into full output")

endmodule

`default_nettype wire

### design/fdc_out_reg.sv
// result register on the master side
`default_nettype none

module fdc_out_reg (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_load,
    input  wire fdc_pkg::t_result i_res,
    output logic                  o_free,
    output logic                  o_valid,
    input  wire                   i_ready,
    output fdc_pkg::t_result      o_res
);
    import fdc_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

### design/frame_delimiter_checksum_check_top.sv
// an accepted idle passes the input register, then the result register, to m_axis
// throughput: one transaction per cycle, set by the input register and the result register
// bytes keep flowing while a status waits; only an idle waits for a free result register
// reset (synchronous, active low) clears both markers and all frame state, no clearing pass
`default_nettype none

module frame_delimiter_checksum_check_top #(
    parameter int MAX_FRAME = fdc_pkg::MAX_FRAME_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [7:0]                          s_axis_tdata,  // data_byte
    input  wire  [0:0]                          s_axis_tuser,  // command
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [15:0]                         m_axis_tdata,  // status, frame_length, zeros
    input  wire                                 i_cfg_we,
    input  wire  [fdc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [fdc_pkg::CFG_W-1:0]           i_cfg_data
);
    import fdc_pkg::*;

    t_item   w_in_item;
    t_item   w_item;
    t_result w_res;
    t_result w_out_res;
    logic    w_valid;
    logic    w_take;
    logic    w_load;
    logic    w_out_free;

    assign w_in_item.command   = t_cmd'(s_axis_tuser[0]);
    assign w_in_item.data_byte = s_axis_tdata;

    fdc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .i_take  (w_take),
        .o_valid (w_valid),
        .o_item  (w_item)
    );

    fdc_frame #(
        .MAX_FRAME (MAX_FRAME)
    ) u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (w_valid),
        .i_item     (w_item),
        .i_out_free (w_out_free),
        .o_take     (w_take),
        .o_load     (w_load),
        .o_res      (w_res)
    );

    fdc_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_out_res)
    );

    assign m_axis_tdata = {5'b0, w_out_res.frame_length, w_out_res.status};

endmodule

`default_nettype wire

### bench/tb_frame_delimiter_checksum_check_top.sv
// testbench for the frame delimiter and checksum check: directed and random frames, self-checking
`timescale 1ns / 100ps

module tb_frame_delimiter_checksum_check_top;

    import fdc_pkg::*;

    localparam int              MAX_REPORTS    = 10;
    localparam int              HOLD_CYCLES    = 300;
    localparam int              SETTLE_CYCLES  = 4;
    localparam int              WATCHDOG_LIMIT = 3000;
    localparam int              RANDOM_ITEMS   = 230;
    localparam logic [8:0]      KEEP_MAX       = 9'(MAX_FRAME_DEF);

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum int {
        FLAW_NONE,
        FLAW_START,
        FLAW_END,
        FLAW_LEN,
        FLAW_SUM
    } t_flaw;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // data_byte
    logic [0:0]             s_axis_tuser;   // command
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [15:0]            m_axis_tdata;   // status, frame_length, zeros
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_W-1:0]       i_cfg_data;

    // frame tracker state, mirrors what the block keeps for the open frame
    logic [7:0]             mark_start = 8'h00;
    logic [7:0]             mark_end   = 8'h00;
    logic [8:0]             fr_count   = '0;
    logic [7:0]             fr_first   = '0;
    logic [7:0]             fr_decl    = '0;
    logic [7:0]             fr_last    = '0;
    logic [7:0]             fr_prev    = '0;
    logic [7:0]             fr_sum     = '0;

    t_result                status_q[$];
    logic [7:0]             frame_buf[$];
    t_result                seen_status;
    t_result                want_status;

    int unsigned            fail_count   = 0;
    int unsigned            items_sent   = 0;
    int unsigned            stall_cycles = 0;
    logic                   no_gaps      = 1'b0;
    logic                   hold_req     = 1'b0;

    frame_delimiter_checksum_check_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void take_rx_byte(input logic [7:0] b);
        if (fr_count >= KEEP_MAX) return;
        if (fr_count == 9'd0) fr_first = b;
        if (fr_count == 9'd1) fr_decl = b;
        // sum runs two bytes behind the newest one
        if (fr_count >= 9'd2) fr_sum = fr_sum + fr_prev;
        fr_prev  = fr_last;
        fr_last  = b;
        fr_count = fr_count + 9'd1;
    endfunction

    function automatic t_result close_frame();
        t_result r;
        if (fr_count < 9'd2 || fr_first != mark_start || fr_last != mark_end) begin
            r.status = ST_DELIM;
        end else if (fr_count < {1'b0, fr_decl}) begin
            r.status = ST_LEN;
        end else if (fr_sum != fr_prev) begin
            r.status = ST_SUM;
        end else begin
            r.status = ST_OK;
        end
        r.frame_length = fr_count;
        fr_count = '0;
        fr_first = '0;
        fr_decl  = '0;
        fr_last  = '0;
        fr_prev  = '0;
        fr_sum   = '0;
        return r;
    endfunction

    function automatic logic [7:0] pick_marker();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 8'h00;
        if (r < 30) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input t_cmd cmd, input logic [7:0] b);
        @(negedge i_clk);
        while (!no_gaps && $urandom_range(0, 99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (cmd == CMD_BYTE) begin
            take_rx_byte(b);
        end else begin
            status_q.push_back(close_frame());
        end
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) send_item(CMD_BYTE, frame_buf[i]);
        send_item(CMD_IDLE, 8'($urandom_range(0, 255)));
    endtask

    // random frame of n bytes; with four or more kept bytes it passes every check unless a flaw is asked for
    task automatic build_frame(input int n, input t_flaw flaw);
        int         kept;
        logic [7:0] sum;
        frame_buf.delete();
        kept = (n > MAX_FRAME_DEF) ? MAX_FRAME_DEF : n;
        for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
        if (kept >= 4) begin
            if (flaw == FLAW_LEN && kept < 255) begin
                frame_buf[1] = 8'($urandom_range(kept + 1, 255));
            end else begin
                frame_buf[1] = 8'($urandom_range(0, (kept > 255) ? 255 : kept));
            end
        end
        if (kept >= 1) begin
            frame_buf[0] = mark_start;
            if (flaw == FLAW_START) frame_buf[0] ^= 8'($urandom_range(1, 255));
        end
        if (kept >= 3) begin
            sum = 8'h00;
            for (int i = 0; i < kept - 2; i++) sum += frame_buf[i];
            frame_buf[kept-2] = sum;
            if (flaw == FLAW_SUM) frame_buf[kept-2] ^= 8'($urandom_range(1, 255));
        end
        if (kept >= 2) begin
            frame_buf[kept-1] = mark_end;
            if (flaw == FLAW_END) frame_buf[kept-1] ^= 8'($urandom_range(1, 255));
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        // an accepted byte may still sit in the input register
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_START) begin
            mark_start = val;
        end else if (idx == CFG_END) begin
            mark_end = val;
        end
    endtask

    // an idle with no bytes and a one-byte frame, reset markers
    task automatic test_short_frames();
        send_item(CMD_IDLE, 8'hFF);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_IDLE, 8'h00);
    endtask

    task automatic test_registers();
        write_reg(CFG_START, 8'hFF);
        write_reg(CFG_END, 8'h00);
        write_reg(CFG_SPARE_A, 8'h5A);
        write_reg(CFG_SPARE_B, 8'hA5);
        build_frame(5, FLAW_NONE);
        send_frame();
    endtask

    // two bytes leave nothing to sum, three bytes sum only the first
    task automatic test_tiny_frames();
        write_reg(CFG_START, 8'h00);
        write_reg(CFG_END, 8'h02);
        build_frame(2, FLAW_NONE);
        send_frame();
        build_frame(3, FLAW_NONE);
        send_frame();
    endtask

    task automatic test_each_status();
        write_reg(CFG_START, 8'hA5);
        write_reg(CFG_END, 8'hFF);
        for (int k = 0; k <= int'(FLAW_SUM); k++) begin
            build_frame(4, t_flaw'(k));
            send_frame();
        end
    endtask

    // fills the buffer, then bytes beyond it that must be dropped
    task automatic test_overflow();
        build_frame($urandom_range(MAX_FRAME_DEF + 1, MAX_FRAME_DEF + 8), FLAW_NONE);
        send_frame();
    endtask

    task automatic test_burst();
        no_gaps = 1'b1;
        repeat (15) begin
            build_frame($urandom_range(2, 12), FLAW_NONE);
            send_frame();
        end
        wait_drained();
        no_gaps = 1'b0;
    endtask

    // result side stalls long enough for an idle to back up the input
    task automatic test_hold_off();
        hold_req = 1'b1;
        repeat (10) begin
            build_frame($urandom_range(2, 6), FLAW_NONE);
            send_frame();
        end
        wait_drained();
    endtask

    task automatic test_random(input int unsigned target);
        int unsigned first_item;
        int          frames;
        int          r;
        t_flaw       flaw;
        first_item = items_sent;
        frames = 0;
        while (items_sent - first_item < target) begin
            if (frames % 12 == 11) begin
                write_reg(CFG_START, pick_marker());
                write_reg(CFG_END, pick_marker());
            end
            r = $urandom_range(0, 99);
            if (r < 65) begin
                flaw = ($urandom_range(0, 1) == 0) ? FLAW_NONE : t_flaw'($urandom_range(1, 4));
                build_frame($urandom_range(2, 20), flaw);
            end else if (r < 75) begin
                build_frame($urandom_range(21, 64), FLAW_NONE);
            end else begin
                // unstructured bytes, including empty and single-byte frames
                frame_buf.delete();
                repeat ($urandom_range(0, 8)) frame_buf.push_back(8'($urandom_range(0, 255)));
            end
            send_frame();
            frames++;
        end
    endtask

    // result side: random back-pressure, quiet stretches and one long hold-off
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 9);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_status.status       = t_status'(m_axis_tdata[1:0]);
            seen_status.frame_length = m_axis_tdata[LEN_W+1:2];
            if (status_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected status %0d length %0d", $time,
                             seen_status.status, seen_status.frame_length);
                end
            end else begin
                want_status = status_q.pop_front();
                if (seen_status.status != want_status.status ||
                    seen_status.frame_length != want_status.frame_length) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: status %0d length %0d, expected status %0d length %0d",
                                 $time, seen_status.status, seen_status.frame_length,
                                 want_status.status, want_status.frame_length);
                    end
                end
            end
        end
    end

    // cycles in which no transaction of any kind took place
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = CMD_BYTE;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_START;
        i_cfg_data    = 8'h00;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_short_frames();
        test_registers();
        test_tiny_frames();
        test_each_status();
        test_overflow();
        test_burst();
        test_hold_off();
        test_random(RANDOM_ITEMS);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && status_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
